/* hdl/positional_insert_delete_list_assert.svh */
// Assertion macros shared by the list checker.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list checker: next-cycle property failed");

`endif

/* hdl/pidl_pkg.sv */
// Package for the positional insert/delete list: sizes, codes and beat types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package pidl_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] position;
    logic [7:0]       in_tag;
    logic [15:0]      in_priority;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_tag;
    logic [15:0] out_priority;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        is_full;
    logic        is_empty;
  } out_beat_t;

  // Per-cell controls, decoded once per beat in the top level.
  typedef struct packed {
    logic shift_up;
    logic load;
    logic shift_down;
    logic update;
  } cell_ctrl_t;

endpackage

/* hdl/positional_insert_delete_list.sv */
// Top level of the positional insert/delete list: command decode, cell chain
// and result register. Depends on pidl_pkg and pidl_cell.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid / in_stall / in_beat) carries one command per beat:
//   insert at a position, delete at a position, update priority by tag, or
//   clear. Every accepted command yields exactly one result beat on the output
//   channel (out_valid / out_stall / out_beat) with the deleted entry (zero
//   unless a delete succeeded), a status code, and the entry count after it.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput: one command per cycle while no result is held. Every slot is a
//   cell of the chain, so a whole-list shift happens at the result's edge.
//   Stalls: a result held by out_stall keeps its register; the block then
//   stalls its input until the result is taken, and takes the next command in
//   the same cycle the held result leaves.
//   Reset: rst_n (synchronous, active low) empties the list and drops any
//   pending result; in_stall stays high while reset is asserted. Slot
//   contents are not cleared; only slots below the count ever reach the output.
//
module positional_insert_delete_list import pidl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_r, out_nxt;

  logic             accept;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             is_ins, is_del, is_upd, is_clr;
  logic             ins_ok, del_ok;
  logic [1:0]       status;
  entry_t           new_entry;
  entry_t           picked;

  entry_t     slot_q [CAPACITY];
  cell_ctrl_t ctrl   [CAPACITY];

  // Hold the input while a result waits to be taken, and during reset.
  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign pos_ext = CMP_W'(in_beat.position);
  assign cnt_ext = CMP_W'(count_r);

  assign is_ins = (in_beat.operation == OP_INSERT);
  assign is_del = (in_beat.operation == OP_DELETE);
  assign is_upd = (in_beat.operation == OP_UPDATE);
  assign is_clr = (in_beat.operation == OP_CLEAR);

  // Full check before the range check on insert, empty check first on delete.
  assign ins_ok = is_ins && (count_r < CAP_CNT) && (pos_ext <= cnt_ext);
  assign del_ok = is_del && (count_r != '0) && (pos_ext < cnt_ext);

  always_comb begin
    status = ST_OK;
    if (is_ins) begin
      if (count_r >= CAP_CNT) begin
        status = ST_FULL;
      end else if (pos_ext > cnt_ext) begin
        status = ST_RANGE;
      end
    end else if (is_del) begin
      if (count_r == '0) begin
        status = ST_EMPTY;
      end else if (pos_ext >= cnt_ext) begin
        status = ST_RANGE;
      end
    end
  end

  assign new_entry.tag  = in_beat.in_tag;
  assign new_entry.prio = in_beat.in_priority;

  // Cell chain: insert moves the tail up one slot, delete pulls it down one.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(i);
    entry_t left_q, right_q;

    if (i == 0) begin : g_first
      assign left_q = slot_q[i];
    end else begin : g_left
      assign left_q = slot_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_q = slot_q[i];
    end else begin : g_right
      assign right_q = slot_q[i+1];
    end

    assign ctrl[i].load       = accept && ins_ok && (CELL_IDX == pos_ext);
    assign ctrl[i].shift_up   = accept && ins_ok && (CELL_IDX > pos_ext);
    assign ctrl[i].shift_down = accept && del_ok && (CELL_IDX >= pos_ext) &&
                                (i != CAPACITY - 1);
    assign ctrl[i].update     = accept && is_upd;

    pidl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .left_q    (left_q),
      .right_q   (right_q),
      .new_entry (new_entry),
      .slot_q    (slot_q[i])
    );
  end

  // Deleted entry, read before the chain shifts.
  assign picked = del_ok ? slot_q[IDX_W'(in_beat.position)] : '0;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (ins_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (del_ok) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (is_clr) begin
        count_nxt = '0;
      end
    end
  end

  always_comb begin
    out_nxt              = out_r;
    out_valid_nxt        = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt        = 1'b1;
      out_nxt.out_tag      = picked.tag;
      out_nxt.out_priority = picked.prio;
      out_nxt.status       = status;
      out_nxt.entry_count  = 5'(count_nxt);
      out_nxt.is_full      = (count_nxt == CAP_CNT);
      out_nxt.is_empty     = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

/* hdl/pidl_cell.sv */
// One slot of the list chain: holds an entry, takes a neighbor's or a new one, or updates its priority on a tag match.
// Depends on pidl_pkg for the entry and control types.
`timescale 1ns / 1ps

module pidl_cell import pidl_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     left_q,
  input  entry_t     right_q,
  input  entry_t     new_entry,
  output entry_t     slot_q
);

  entry_t slot_r;
  entry_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.load) begin
      slot_nxt = new_entry;
    end else if (ctrl.shift_up) begin
      slot_nxt = left_q;
    end else if (ctrl.shift_down) begin
      slot_nxt = right_q;
    end else if (ctrl.update && (slot_r.tag == new_entry.tag)) begin
      slot_nxt.prio = new_entry.prio;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q = slot_r;

endmodule

/* hdl/pidl_checker.sv */
// Port-level checker for the positional insert/delete list, bound to the top.
// Depends on pidl_pkg and positional_insert_delete_list_assert.svh.
`timescale 1ns / 1ps
`include "positional_insert_delete_list_assert.svh"

module pidl_checker import pidl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_beat
);

  // A stalled result holds its beat.
  `PIDL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

  // Every accepted command yields a result beat in the next cycle.
  `PIDL_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid)

  // Outside reset, with no result pending the block never stalls its input.
  `PIDL_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall)

  // A failed command returns no entry, and an empty list reports a zero count.
  `PIDL_ASSERT_NOW(a_fail_zero, out_valid && (out_beat.status != ST_OK),
                   (out_beat.out_tag == '0) && (out_beat.out_priority == '0))
  `PIDL_ASSERT_NOW(a_empty_count, out_valid && out_beat.is_empty,
                   (out_beat.entry_count == '0) && !out_beat.is_full)

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (.*);
